// ----- rtl/sdit_pkg.sv -----
// Shared types, constants and the saturation helper of the stream derivative/integral transform.
package sdit_pkg;

  // Field widths.
  localparam int unsigned SampleW = 32;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned ResW    = 48;
  localparam int unsigned GainW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned SumW    = 52;
  localparam int unsigned MagW    = 50;

  // Divider sizing: the dividend register holds 48 bits, the divisor 32.
  localparam int unsigned DivNumW = 48;
  localparam int unsigned DivDenW = 32;
  localparam int unsigned DivCntW = 6;

  localparam logic [DivCntW-1:0] DIV_LEN_WRAP = 6'd32;
  localparam logic [DivCntW-1:0] DIV_LEN_QUOT = 6'd48;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_MODE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CYCLIC = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_WRAP   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GAIN   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET = 3'd4;

  // Transform modes.
  localparam logic [1:0] MODE_RAW = 2'd0;
  localparam logic [1:0] MODE_DER = 2'd1;
  localparam logic [1:0] MODE_INT = 2'd2;
  localparam logic [1:0] MODE_CUM = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [TimeW-1:0] WRAP_RESET = 32'd411775;
  localparam logic [GainW-1:0] GAIN_RESET = 32'd65536;

  // Status of the iterative divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Saturate a wide signed sum into the signed 48-bit result range.
  function automatic logic [ResW-1:0] sat48(input logic [SumW-1:0] v);
    logic all_same;
    all_same = (v[SumW-1:ResW-1] == '0) || (v[SumW-1:ResW-1] == '1);
    if (all_same) begin
      sat48 = v[ResW-1:0];
    end else if (v[SumW-1]) begin
      sat48 = {1'b1, {(ResW-1){1'b0}}};
    end else begin
      sat48 = {1'b0, {(ResW-1){1'b1}}};
    end
  endfunction

endpackage

// ----- rtl/stream_derivative_integral_transform.sv -----
// Top level: sequencer and datapath of the stream derivative/integral transform.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------------------------
//   input   | in        | in_valid_i / in_stall_o   | sample, sample_ok, timestamp, first
//   output  | out       | out_valid_o / out_stall_i | transformed(_valid), scaled, raw_valid
//   config  | in        | cfg_we_i                  | cfg_index_i, cfg_wdata_i
//
// An item passes from transfer to result quickest in raw mode or for short cases, and
// slowest for a cyclic derivative: the shared divider computes the wrap remainder and
// then the quotient, and each scaling or integral product goes through the shared
// multiplier. in_stall_o is high while an item is in progress.
// Reset clears the configuration to its defaults and the sample history; a mode write
// clears the history too. A stalled result waits in the output register; the next input
// transfer is taken meanwhile, and that item holds at its last step until the result leaves.
module stream_derivative_integral_transform import sdit_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      sample_ok_i,
  input  logic        [TimeW-1:0]   timestamp_i,
  input  logic                      first_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [ResW-1:0]    transformed_o,
  output logic                      transformed_valid_o,
  output logic signed [ResW-1:0]    scaled_o,
  output logic                      raw_valid_o,
  input  logic                      cfg_we_i,
  input  logic        [CfgIdxW-1:0] cfg_index_i,
  input  logic        [ResW-1:0]    cfg_wdata_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIFF  = 4'd1;
  localparam logic [3:0] S_WRAP  = 4'd2;
  localparam logic [3:0] S_FOLD  = 4'd3;
  localparam logic [3:0] S_MAIN  = 4'd4;
  localparam logic [3:0] S_QUOT  = 4'd5;
  localparam logic [3:0] S_SCALE = 4'd6;
  localparam logic [3:0] S_MLO   = 4'd7;
  localparam logic [3:0] S_MHI   = 4'd8;
  localparam logic [3:0] S_MCAP  = 4'd9;
  localparam logic [3:0] S_MADD  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state_q, state_d;

  // Configuration registers.
  logic [1:0]         mode_q;
  logic               cyclic_q;
  logic [TimeW-1:0]   wrap_q;
  logic [GainW-1:0]   gain_q;
  logic [ResW-1:0]    offset_q;

  // History of the previous entry.
  logic [SampleW-1:0] last_sample_q;
  logic               lsv_q;
  logic [ResW-1:0]    last_result_q;
  logic               lrv_q;
  logic [TimeW-1:0]   last_time_q;

  // Current item and working registers.
  logic [SampleW-1:0] cur_q;
  logic               ok_q;
  logic [TimeW-1:0]   ts_q;
  logic               first_q;
  logic [SampleW:0]   d_q;
  logic [SampleW:0]   dt_q;
  logic [SampleW:0]   wd_q;
  logic [TimeW-1:0]   mw_q;
  logic               neg_q;
  logic [ResW-1:0]    tr_q;
  logic               tv_q;
  logic [ResW-1:0]    scaled_q;
  logic [ResW-1:0]    ma_q;
  logic [GainW-1:0]   mb_q;
  logic               mint_q;
  logic [63:0]        lo_q;
  logic [MagW-1:0]    m_q;

  // Output register.
  logic               out_valid_q;
  logic [ResW-1:0]    tr_out_q;
  logic               tv_out_q;
  logic [ResW-1:0]    sc_out_q;
  logic               rv_out_q;

  // Shared units.
  logic               div_start;
  logic [DivCntW-1:0] div_len;
  logic [DivNumW-1:0] div_num;
  logic [DivDenW-1:0] div_den;
  div_stat_t          div_stat;
  logic [DivNumW-1:0] div_quot;
  logic [DivDenW-1:0] div_rem;
  logic               mul_en;
  logic [31:0]        mul_a;
  logic [63:0]        mul_prod;

  // Combinational datapath.
  logic [SampleW:0]   dt_w;
  logic [SampleW:0]   d_w;
  logic [SampleW:0]   d_mag;
  logic [SampleW:0]   dt_mag;
  logic [SampleW:0]   wd_mag;
  logic [TimeW-1:0]   rem_adj;
  logic               fold_ge;
  logic [SampleW:0]   wd_fold;
  logic [SampleW+1:0] t_w;
  logic [SampleW+1:0] t_mag;
  logic [SumW-1:0]    base_w;
  logic [SumW-1:0]    cum_w;
  logic [SumW-1:0]    q_signed;
  logic               mul_cap;
  logic [MagW-1:0]    m_calc;
  logic [SumW-1:0]    sm_w;
  logic [ResW-1:0]    tr_mag;
  logic [GainW-1:0]   gain_mag;
  logic               wrap_on;
  logic               out_load;
  logic [ResW-1:0]    diff_tr;
  logic               diff_tv;
  logic [3:0]         diff_next;

  // Time and sample differences of the item against the stored entry.
  assign dt_w = {1'b0, ts_q} - {1'b0, last_time_q};
  assign d_w  = {cur_q[SampleW-1], cur_q} - {last_sample_q[SampleW-1], last_sample_q};

  assign d_mag  = d_w[SampleW]  ? -d_w  : d_w;
  assign dt_mag = dt_q[SampleW] ? -dt_q : dt_q;
  assign wd_mag = wd_q[SampleW] ? -wd_q : wd_q;

  assign wrap_on = cyclic_q && (wrap_q != '0);

  // Turn the remainder of the magnitude into a floored modulo, then fold to the half range.
  assign rem_adj = (d_q[SampleW] && (div_rem != '0)) ? wrap_q - div_rem : div_rem;
  assign fold_ge = {mw_q, 1'b0} >= {1'b0, wrap_q};
  assign wd_fold = fold_ge ? {1'b0, mw_q} - {1'b0, wrap_q} : {1'b0, mw_q};

  // Trapezoid term: twice the previous sample plus the (wrapped) difference.
  assign t_w   = {last_sample_q[SampleW-1], last_sample_q, 1'b0} + {wd_q[SampleW], wd_q};
  assign t_mag = t_w[SampleW+1] ? -t_w : t_w;

  assign base_w = lrv_q ? {{(SumW-ResW){last_result_q[ResW-1]}}, last_result_q} : '0;
  assign cum_w  = base_w + {{(SumW-SampleW){last_sample_q[SampleW-1]}}, last_sample_q}
                + {{(SumW-SampleW-1){wd_q[SampleW]}}, wd_q};

  assign q_signed = neg_q ? -{{(SumW-DivNumW){1'b0}}, div_quot}
                          :  {{(SumW-DivNumW){1'b0}}, div_quot};

  // Shifted product from the two partial products; a huge product is capped near 2^49.
  always_comb begin
    if (mint_q) begin
      mul_cap = |mul_prod[47:33];
      m_calc  = MagW'({mul_prod[32:0], 15'b0}) + MagW'(lo_q[63:17]);
    end else begin
      mul_cap = |mul_prod[47:32];
      m_calc  = MagW'({mul_prod[31:0], 16'b0}) + MagW'(lo_q[63:16]);
    end
    if (mul_cap) begin
      m_calc = {1'b1, {(MagW-1){1'b0}}};
    end
  end

  assign sm_w     = neg_q ? -{2'b00, m_q} : {2'b00, m_q};
  assign tr_mag   = tr_q[ResW-1] ? -tr_q : tr_q;
  assign gain_mag = gain_q[GainW-1] ? -gain_q : gain_q;

  // Sort the item into its case and pick the first value of the result.
  always_comb begin
    diff_tr   = '0;
    diff_tv   = 1'b0;
    diff_next = S_OUT;
    if (!ok_q) begin
      diff_next = S_OUT;
    end else if (first_q) begin
      case (mode_q)
        MODE_RAW, MODE_CUM: begin
          diff_tr   = {{(ResW-SampleW){cur_q[SampleW-1]}}, cur_q};
          diff_tv   = 1'b1;
          diff_next = S_SCALE;
        end
        MODE_INT: begin
          diff_tv   = 1'b1;
          diff_next = S_SCALE;
        end
        default: begin
          diff_next = S_OUT;
        end
      endcase
    end else if (mode_q == MODE_RAW) begin
      diff_tr   = {{(ResW-SampleW){cur_q[SampleW-1]}}, cur_q};
      diff_tv   = 1'b1;
      diff_next = S_SCALE;
    end else if ((mode_q == MODE_DER) && ((dt_w == '0) || !lsv_q)) begin
      diff_next = S_OUT;
    end else if (!lsv_q) begin
      diff_tv   = 1'b1;
      diff_tr   = (mode_q == MODE_CUM) ? {{(ResW-SampleW){cur_q[SampleW-1]}}, cur_q} : '0;
      diff_next = S_SCALE;
    end else begin
      diff_tv   = 1'b1;
      diff_next = wrap_on ? S_WRAP : S_MAIN;
    end
  end

  // Divider requests: the wrap remainder first, the derivative quotient later.
  always_comb begin
    if (state_q == S_DIFF) begin
      div_start = (diff_next == S_WRAP);
      div_len   = DIV_LEN_WRAP;
      div_num   = {d_mag[SampleW-1:0], 16'b0};
      div_den   = wrap_q;
    end else begin
      div_start = (state_q == S_MAIN) && (mode_q == MODE_DER);
      div_len   = DIV_LEN_QUOT;
      div_num   = {wd_mag[SampleW-1:0], 16'b0};
      div_den   = dt_mag[SampleW-1:0];
    end
  end

  // Multiplier operands: low word of the magnitude, then its high part.
  assign mul_en = (state_q == S_MLO) || (state_q == S_MHI);
  assign mul_a  = (state_q == S_MHI) ? {16'b0, ma_q[ResW-1:32]} : ma_q[31:0];

  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_DIFF;
      S_DIFF:  state_d = diff_next;
      S_WRAP:  if (div_stat.done) state_d = S_FOLD;
      S_FOLD:  state_d = S_MAIN;
      S_MAIN: begin
        case (mode_q)
          MODE_DER: state_d = S_QUOT;
          MODE_INT: state_d = S_MLO;
          default:  state_d = S_SCALE;
        endcase
      end
      S_QUOT:  if (div_stat.done) state_d = S_SCALE;
      S_SCALE: state_d = S_MLO;
      S_MLO:   state_d = S_MHI;
      S_MHI:   state_d = S_MCAP;
      S_MCAP:  state_d = S_MADD;
      S_MADD:  state_d = mint_q ? S_SCALE : S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state, configuration, history and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      mode_q        <= MODE_RAW;
      cyclic_q      <= 1'b0;
      wrap_q        <= WRAP_RESET;
      gain_q        <= GAIN_RESET;
      offset_q      <= '0;
      last_sample_q <= '0;
      lsv_q         <= 1'b0;
      last_result_q <= '0;
      lrv_q         <= 1'b0;
      last_time_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (out_load) begin
        last_sample_q <= ok_q ? cur_q : '0;
        lsv_q         <= ok_q;
        last_result_q <= tr_q;
        lrv_q         <= tv_q;
        last_time_q   <= ts_q;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MODE: begin
            mode_q        <= cfg_wdata_i[1:0];
            last_sample_q <= '0;
            lsv_q         <= 1'b0;
            last_result_q <= '0;
            lrv_q         <= 1'b0;
            last_time_q   <= '0;
          end
          CFG_CYCLIC: cyclic_q <= cfg_wdata_i[0];
          CFG_WRAP:   wrap_q   <= cfg_wdata_i[TimeW-1:0];
          CFG_GAIN:   gain_q   <= cfg_wdata_i[GainW-1:0];
          CFG_OFFSET: offset_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Working registers, loaded step by step.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cur_q   <= sample_i;
          ok_q    <= sample_ok_i;
          ts_q    <= timestamp_i;
          first_q <= first_i;
        end
      end
      S_DIFF: begin
        d_q      <= d_w;
        dt_q     <= dt_w;
        wd_q     <= d_w;
        tr_q     <= diff_tr;
        tv_q     <= diff_tv;
        scaled_q <= '0;
      end
      S_WRAP: begin
        if (div_stat.done) begin
          mw_q <= rem_adj;
        end
      end
      S_FOLD: begin
        wd_q <= wd_fold;
      end
      S_MAIN: begin
        case (mode_q)
          MODE_DER: neg_q <= wd_q[SampleW] ^ dt_q[SampleW];
          MODE_INT: begin
            ma_q   <= ResW'(t_mag);
            mb_q   <= dt_mag[SampleW-1:0];
            neg_q  <= t_w[SampleW+1] ^ dt_q[SampleW];
            mint_q <= 1'b1;
          end
          default: tr_q <= sat48(cum_w);
        endcase
      end
      S_QUOT: begin
        if (div_stat.done) begin
          tr_q <= sat48(q_signed);
        end
      end
      S_SCALE: begin
        ma_q   <= tr_mag;
        mb_q   <= gain_mag;
        neg_q  <= tr_q[ResW-1] ^ gain_q[GainW-1];
        mint_q <= 1'b0;
      end
      S_MHI: begin
        lo_q <= mul_prod;
      end
      S_MCAP: begin
        m_q <= m_calc;
      end
      S_MADD: begin
        if (mint_q) begin
          tr_q <= sat48(base_w + sm_w);
        end else begin
          scaled_q <= sat48(sm_w + {{(SumW-ResW){offset_q[ResW-1]}}, offset_q});
        end
      end
      default: ;
    endcase
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      tr_out_q <= tr_q;
      tv_out_q <= tv_q;
      sc_out_q <= scaled_q;
      rv_out_q <= ok_q;
    end
  end

  sdit_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .len_i      (div_len),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  sdit_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mb_q),
    .prod_o (mul_prod)
  );

  assign in_stall_o          = (state_q != S_IDLE);
  assign out_valid_o         = out_valid_q;
  assign transformed_o       = tr_out_q;
  assign transformed_valid_o = tv_out_q;
  assign scaled_o            = sc_out_q;
  assign raw_valid_o         = rv_out_q;

endmodule

// ----- rtl/sdit_div.sv -----
// Restoring radix-2 divider that produces one quotient bit per cycle.
module sdit_div import sdit_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivCntW-1:0] len_i,
  input  logic [DivNumW-1:0] dividend_i,
  input  logic [DivDenW-1:0] divisor_i,
  output div_stat_t          stat_o,
  output logic [DivNumW-1:0] quot_o,
  output logic [DivDenW-1:0] rem_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivNumW-1:0] acc_q;
  logic [DivDenW-1:0] rem_q;
  logic [DivDenW-1:0] dsr_q;

  logic [DivDenW:0]   trial;
  logic [DivDenW+1:0] diff;
  logic               ge;

  // One trial subtraction of the shifted partial remainder.
  assign trial = {rem_q, acc_q[DivNumW-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsr_q};
  assign ge    = ~diff[DivDenW+1];

  // Control: iteration counter and the one-cycle done flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= len_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == {{(DivCntW-1){1'b0}}, 1'b1}) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[DivNumW-2:0], ge};
      rem_q <= ge ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = acc_q;
  assign rem_o       = rem_q;

endmodule

// ----- rtl/sdit_mul.sv -----
// Shared 32 by 32 unsigned multiplier with a registered product.
module sdit_mul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;

  // The product of the enabled operands is registered and appears in the next cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/sdit_checker.sv -----
// Port-level assertions of the stream derivative/integral transform and their bind.
module sdit_checker import sdit_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic signed [SampleW-1:0] sample_i,
  input logic                      sample_ok_i,
  input logic        [TimeW-1:0]   timestamp_i,
  input logic                      first_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic signed [ResW-1:0]    transformed_o,
  input logic                      transformed_valid_o,
  input logic signed [ResW-1:0]    scaled_o,
  input logic                      raw_valid_o,
  input logic                      cfg_we_i,
  input logic        [CfgIdxW-1:0] cfg_index_i,
  input logic        [ResW-1:0]    cfg_wdata_i
);

  // Only one item is in progress: after an input transfer the input side stalls.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while an item was still in progress");

  // An invalid result carries zero in both value fields.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !transformed_valid_o) |-> (transformed_o == '0 && scaled_o == '0))
    else $error("invalid result with nonzero value");

  // An unavailable sample never yields a valid transformed value.
  a_raw_gates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !raw_valid_o) |-> !transformed_valid_o)
    else $error("valid result from an unavailable sample");

  // A stalled result stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(transformed_o) && $stable(scaled_o)))
    else $error("stalled result changed");

endmodule

bind stream_derivative_integral_transform sdit_checker u_sdit_checker (.*);
